// ----- rtl/core/assert_macros.svh -----
// Concurrent assertion helpers, empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, cond, expr)

`define ASSERT_NEXT(label, clk, rst_n, cond, expr)

`endif

`endif

// ----- rtl/core/tcce_pkg.sv -----
package tcce_pkg;

    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;

    localparam logic [2:0] ACT_PUT     = 3'd0;
    localparam logic [2:0] ACT_BLINK   = 3'd1;
    localparam logic [2:0] ACT_CUR_ON  = 3'd2;
    localparam logic [2:0] ACT_CUR_OFF = 3'd3;
    localparam logic [2:0] ACT_CLEAR   = 3'd4;

    localparam logic [1:0] CMD_FILL   = 2'd0;
    localparam logic [1:0] CMD_GLYPH  = 2'd1;
    localparam logic [1:0] CMD_SCROLL = 2'd2;

    localparam logic [1:0] CFG_TEXT_SIZE = 2'd0;
    localparam logic [1:0] CFG_SCR_W     = 2'd1;
    localparam logic [1:0] CFG_SCR_H     = 2'd2;

    localparam logic [4:0]  TEXT_SIZE_RST = 5'd4;
    localparam logic [12:0] SCR_W_RST     = 13'd1024;
    localparam logic [12:0] SCR_H_RST     = 13'd768;

    localparam logic [7:0]  CH_LF        = 8'd10;
    localparam logic [7:0]  CH_CR        = 8'd13;
    localparam logic [7:0]  CH_BS        = 8'd8;
    localparam logic [6:0]  CURSOR_GLYPH = 7'h5F;
    localparam logic [23:0] CURSOR_PAINT = 24'hFFFFFF;
    localparam logic [23:0] BG_PAINT     = 24'h000000;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  char_code;
        logic [23:0] color;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  command;
        logic [12:0] left;
        logic [12:0] top;
        logic [12:0] right;
        logic [12:0] bottom;
        logic [6:0]  glyph_code;
        logic [23:0] paint;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  command;
        logic [12:0] left;
        logic [12:0] top;
        logic [12:0] right;
        logic [12:0] bottom;
        logic [6:0]  glyph_code;
        logic [23:0] paint;
        logic        last;
    } t_out_item;

endpackage

// ----- rtl/core/text_console_cursor_engine.sv -----
// An input is registered in r_in, then its commands in the command buffer, which drives the output.
// Throughput: one input per cycle when it yields at most one command and the output is not
// stalled; an input that yields several commands holds the buffer while they are taken one by one.
// Reset: synchronous, active low; cursor at 0,0 with both flags clear, registers
// return to text size 4 and a 1024 x 768 screen.
`include "assert_macros.svh"

module text_console_cursor_engine import tcce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    localparam int NSLOT = 8;
    localparam int SL_ERASE = 0;
    localparam int SL_MAIN  = 1;
    localparam int SL_NL1_S = 2;
    localparam int SL_NL1_F = 3;
    localparam int SL_NL2_S = 4;
    localparam int SL_NL2_F = 5;
    localparam int SL_DRAW  = 6;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_slot;

    typedef struct packed {
        t_slot       scr;
        t_slot       fil;
        logic [12:0] cy;
    } t_nl;

    function automatic t_slot make_fill(input logic [13:0] x0, input logic [13:0] y0,
                                        input logic [13:0] x1, input logic [13:0] y1,
                                        input logic [13:0] w, input logic [13:0] h,
                                        input logic [23:0] c);
        t_slot s;
        logic [13:0] rx;
        logic [13:0] ry;
        s.valid = (x1 > x0) && (y1 > y0) && (x0 < w) && (y0 < h);
        rx = (x1 > w) ? w : x1;
        ry = (y1 > h) ? h : y1;
        s.cmd.command = CMD_FILL;
        s.cmd.left = x0[12:0];
        s.cmd.top = y0[12:0];
        s.cmd.right = rx[12:0];
        s.cmd.bottom = ry[12:0];
        s.cmd.glyph_code = '0;
        s.cmd.paint = c;
        return s;
    endfunction

    function automatic t_slot make_glyph(input logic [12:0] x, input logic [12:0] y,
                                         input logic [6:0] g, input logic [23:0] c);
        t_slot s;
        s.valid = 1'b1;
        s.cmd.command = CMD_GLYPH;
        s.cmd.left = x;
        s.cmd.top = y;
        s.cmd.right = '0;
        s.cmd.bottom = '0;
        s.cmd.glyph_code = g;
        s.cmd.paint = c;
        return s;
    endfunction

    function automatic t_nl new_line(input logic [12:0] cy, input logic [13:0] sy,
                                     input logic [13:0] w, input logic [13:0] h);
        t_nl r;
        logic [13:0] sum;
        logic [13:0] top_row;
        sum = {1'b0, cy} + sy;
        top_row = h - sy;
        r.scr.valid = 1'b0;
        r.scr.cmd.command = CMD_SCROLL;
        r.scr.cmd.left = '0;
        r.scr.cmd.top = '0;
        r.scr.cmd.right = '0;
        r.scr.cmd.bottom = sy[12:0];
        r.scr.cmd.glyph_code = '0;
        r.scr.cmd.paint = '0;
        r.fil = '0;
        r.cy = '0;
        if (sum < h) begin
            r.cy = sum[12:0];
            r.fil = make_fill(14'd0, sum, w, sum + sy, w, h, BG_PAINT);
        end else begin
            r.scr.valid = 1'b1;
            if (sy <= h) begin
                r.fil = make_fill(14'd0, top_row, w, h, w, h, BG_PAINT);
                r.cy = top_row[12:0];
            end
        end
        return r;
    endfunction

    logic [4:0]  r_text_size;
    logic [12:0] r_scr_w;
    logic [12:0] r_scr_h;
    logic [12:0] r_cursor_x;
    logic [12:0] r_cursor_y;
    logic        r_cursor_en;
    logic        r_cursor_shown;
    logic        r_in_valid;
    t_in_item    r_in;
    logic [NSLOT-1:0] r_mask;
    t_cmd        r_slot [NSLOT];

    logic [12:0] n_cursor_x;
    logic [12:0] n_cursor_y;
    logic        n_cursor_en;
    logic        n_cursor_shown;
    logic [NSLOT-1:0] n_mask;
    t_cmd        n_cmd [NSLOT];

    logic [NSLOT-1:0] rest;
    logic [2:0]  head;
    logic        out_acc;
    logic        buf_free;
    logic        load;

    always_comb begin
        t_slot       slot [NSLOT];
        t_slot       erase;
        t_nl         nl1;
        t_nl         nl2;
        logic [13:0] w;
        logic [13:0] h;
        logic [13:0] px;
        logic [13:0] py;
        logic [13:0] sx;
        logic [13:0] sy;
        logic [13:0] x14;
        logic [13:0] y14;
        logic [12:0] cx_mid;
        logic [12:0] cy_mid;
        logic        is_nl;
        logic        is_bs;
        logic        bs_ok;
        logic        adv_fit;
        logic        fits;

        w = {1'b0, r_scr_w};
        h = {1'b0, r_scr_h};
        px = (14'(GLYPH_WIDTH) * {9'd0, r_text_size}) >> 2;
        py = (14'(GLYPH_HEIGHT) * {9'd0, r_text_size}) >> 2;
        sx = (px == '0) ? 14'd1 : px;
        sy = (py == '0) ? 14'd1 : py;
        x14 = {1'b0, r_cursor_x};
        y14 = {1'b0, r_cursor_y};

        for (int i = 0; i < NSLOT; i++) begin
            slot[i] = '0;
        end
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_cursor_en = r_cursor_en;
        n_cursor_shown = r_cursor_shown;

        erase = make_fill(x14, y14, x14 + sx, y14 + sy, w, h, BG_PAINT);
        nl1 = new_line(r_cursor_y, sy, w, h);

        is_nl = (r_in.char_code == CH_LF) || (r_in.char_code == CH_CR);
        is_bs = (r_in.char_code == CH_BS);
        bs_ok = (x14 >= sx);
        adv_fit = ((x14 + sx) < w);
        if (is_bs) begin
            cx_mid = bs_ok ? (r_cursor_x - sx[12:0]) : r_cursor_x;
            cy_mid = r_cursor_y;
        end else if (adv_fit) begin
            cx_mid = r_cursor_x + sx[12:0];
            cy_mid = r_cursor_y;
        end else begin
            cx_mid = '0;
            cy_mid = nl1.cy;
        end
        fits = (({1'b0, cx_mid} + sx - 14'd1) < w) && (({1'b0, cy_mid} + sy - 14'd1) < h);
        nl2 = new_line(cy_mid, sy, w, h);

        case (r_in.action)
            ACT_PUT: begin
                slot[SL_ERASE] = erase;
                slot[SL_ERASE].valid = erase.valid && r_cursor_shown;
                if (is_nl) begin
                    slot[SL_NL1_S] = nl1.scr;
                    slot[SL_NL1_F] = nl1.fil;
                    n_cursor_x = '0;
                    n_cursor_y = nl1.cy;
                end else begin
                    if (is_bs) begin
                        if (bs_ok) begin
                            slot[SL_MAIN] = make_fill({1'b0, cx_mid}, y14, x14, y14 + sy,
                                                      w, h, BG_PAINT);
                        end
                    end else begin
                        slot[SL_MAIN] = make_glyph(r_cursor_x, r_cursor_y,
                                                   r_in.char_code[6:0], r_in.color);
                        slot[SL_MAIN].valid = !r_in.char_code[7];
                        if (!adv_fit) begin
                            slot[SL_NL1_S] = nl1.scr;
                            slot[SL_NL1_F] = nl1.fil;
                        end
                    end
                    n_cursor_x = cx_mid;
                    n_cursor_y = cy_mid;
                    if ((!is_bs || bs_ok) && !fits) begin
                        slot[SL_NL2_S] = nl2.scr;
                        slot[SL_NL2_F] = nl2.fil;
                        n_cursor_x = '0;
                        n_cursor_y = nl2.cy;
                    end
                end
                n_cursor_shown = r_cursor_en;
                if (r_cursor_en) begin
                    slot[SL_DRAW] = make_glyph(n_cursor_x, n_cursor_y, CURSOR_GLYPH,
                                               CURSOR_PAINT);
                end
            end
            ACT_BLINK: begin
                if (r_cursor_en) begin
                    if (r_cursor_shown) begin
                        slot[SL_ERASE] = erase;
                        n_cursor_shown = 1'b0;
                    end else begin
                        slot[SL_DRAW] = make_glyph(r_cursor_x, r_cursor_y, CURSOR_GLYPH,
                                                   CURSOR_PAINT);
                        n_cursor_shown = 1'b1;
                    end
                end
            end
            ACT_CUR_ON: begin
                n_cursor_en = 1'b1;
                if (!r_cursor_shown) begin
                    slot[SL_DRAW] = make_glyph(r_cursor_x, r_cursor_y, CURSOR_GLYPH,
                                               CURSOR_PAINT);
                    n_cursor_shown = 1'b1;
                end
            end
            ACT_CUR_OFF: begin
                if (r_cursor_shown) begin
                    slot[SL_ERASE] = erase;
                end
                n_cursor_shown = 1'b0;
                n_cursor_en = 1'b0;
            end
            ACT_CLEAR: begin
                slot[SL_ERASE] = make_fill(14'd0, 14'd0, w, h, w, h, r_in.color);
                n_cursor_x = '0;
                n_cursor_y = '0;
                n_cursor_shown = r_cursor_en;
                if (r_cursor_en) begin
                    slot[SL_DRAW] = make_glyph(13'd0, 13'd0, CURSOR_GLYPH, CURSOR_PAINT);
                end
            end
            default: begin
            end
        endcase

        for (int i = 0; i < NSLOT; i++) begin
            n_mask[i] = slot[i].valid;
            n_cmd[i] = slot[i].cmd;
        end
    end

    always_comb begin
        head = '0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                head = 3'(i);
            end
        end
    end

    assign rest = r_mask & (r_mask - NSLOT'(1));
    assign o_out_valid = (r_mask != '0);
    assign out_acc = o_out_valid && i_out_ready;
    assign buf_free = (r_mask == '0) || (out_acc && (rest == '0));
    assign load = r_in_valid && buf_free;
    assign o_in_ready = !r_in_valid || load;

    always_comb begin
        o_out_data.command = r_slot[head].command;
        o_out_data.left = r_slot[head].left;
        o_out_data.top = r_slot[head].top;
        o_out_data.right = r_slot[head].right;
        o_out_data.bottom = r_slot[head].bottom;
        o_out_data.glyph_code = r_slot[head].glyph_code;
        o_out_data.paint = r_slot[head].paint;
        o_out_data.last = (rest == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_size <= TEXT_SIZE_RST;
            r_scr_w <= SCR_W_RST;
            r_scr_h <= SCR_H_RST;
            r_cursor_x <= '0;
            r_cursor_y <= '0;
            r_cursor_en <= 1'b0;
            r_cursor_shown <= 1'b0;
            r_in_valid <= 1'b0;
            r_mask <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEXT_SIZE: r_text_size <= i_cfg_data[4:0];
                    CFG_SCR_W: r_scr_w <= i_cfg_data;
                    CFG_SCR_H: r_scr_h <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end
            if (load) begin
                r_mask <= n_mask;
                r_cursor_x <= n_cursor_x;
                r_cursor_y <= n_cursor_y;
                r_cursor_en <= n_cursor_en;
                r_cursor_shown <= n_cursor_shown;
            end else if (out_acc) begin
                r_mask <= rest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (load) begin
            for (int i = 0; i < NSLOT; i++) begin
                r_slot[i] <= n_cmd[i];
            end
        end
    end

    `ASSERT_IMPLY(a_shown_needs_enable, i_clk, i_rst_n, r_cursor_shown, r_cursor_en)
    `ASSERT_NEXT(a_stalled_buffer_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(r_mask))
    `ASSERT_IMPLY(a_empty_buffer_takes_input, i_clk, i_rst_n, r_mask == '0, o_in_ready)

endmodule

// ----- tb/sv/text_console_cursor_engine_test.sv -----
module text_console_cursor_engine_test;
    import tcce_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [12:0] i_cfg_data;

    text_console_cursor_engine dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    localparam int MAX_CMDS_PER_ITEM = 8;

    // console shadow state
    int unsigned cfg_text_size = 32'(TEXT_SIZE_RST);
    int unsigned cfg_scr_w     = 32'(SCR_W_RST);
    int unsigned cfg_scr_h     = 32'(SCR_H_RST);
    int unsigned cur_x         = 0;
    int unsigned cur_y         = 0;
    bit          cursor_on     = 1'b0;
    bit          cursor_drawn  = 1'b0;

    t_out_item   new_cmds[$];
    t_out_item   draw_cmds_due[$];
    t_out_item   next_due;
    int          fail_count = 0;

    bit          in_idle_on       = 1'b1;
    bit          out_idle_on      = 1'b1;
    int          long_hold_cycles = 0;

    function automatic int unsigned cell_w();
        int unsigned s;
        s = (GLYPH_WIDTH * cfg_text_size) / 4;
        return (s != 0) ? s : 1;
    endfunction

    function automatic int unsigned cell_h();
        int unsigned s;
        s = (GLYPH_HEIGHT * cfg_text_size) / 4;
        return (s != 0) ? s : 1;
    endfunction

    function automatic void push_cmd(logic [1:0] cmd, int unsigned l, int unsigned t,
                                     int unsigned r, int unsigned b, logic [6:0] g,
                                     logic [23:0] p);
        t_out_item c;
        if (new_cmds.size() >= MAX_CMDS_PER_ITEM)
            return;
        c.command    = cmd;
        c.left       = l[12:0];
        c.top        = t[12:0];
        c.right      = r[12:0];
        c.bottom     = b[12:0];
        c.glyph_code = g;
        c.paint      = p;
        c.last       = 1'b0;
        new_cmds.push_back(c);
    endfunction

    function automatic void fill_rect(int unsigned x0, int unsigned y0, int unsigned x1,
                                      int unsigned y1, logic [23:0] paint);
        if (x1 <= x0 || y1 <= y0)
            return;
        if (x0 >= cfg_scr_w || y0 >= cfg_scr_h)
            return;
        if (x1 > cfg_scr_w)
            x1 = cfg_scr_w;
        if (y1 > cfg_scr_h)
            y1 = cfg_scr_h;
        push_cmd(CMD_FILL, x0, y0, x1, y1, 7'd0, paint);
    endfunction

    function automatic void line_feed();
        int unsigned sy;
        sy = cell_h();
        cur_x = 0;
        if (cur_y + sy < cfg_scr_h) begin
            cur_y += sy;
            fill_rect(0, cur_y, cfg_scr_w, cur_y + sy, BG_PAINT);
        end else begin
            push_cmd(CMD_SCROLL, 0, 0, 0, sy, 7'd0, 24'd0);
            if (sy <= cfg_scr_h) begin
                fill_rect(0, cfg_scr_h - sy, cfg_scr_w, cfg_scr_h, BG_PAINT);
                cur_y = cfg_scr_h - sy;
            end else begin
                cur_y = 0;
            end
        end
        cur_y &= 32'h1FFF;
    endfunction

    function automatic void keep_cell_on_screen();
        if (!(cur_x + cell_w() - 1 < cfg_scr_w && cur_y + cell_h() - 1 < cfg_scr_h))
            line_feed();
    endfunction

    function automatic void hide_cursor();
        if (!cursor_drawn)
            return;
        fill_rect(cur_x, cur_y, cur_x + cell_w(), cur_y + cell_h(), BG_PAINT);
        cursor_drawn = 1'b0;
    endfunction

    function automatic void show_cursor();
        if (!cursor_on || cursor_drawn)
            return;
        push_cmd(CMD_GLYPH, cur_x, cur_y, 0, 0, CURSOR_GLYPH, CURSOR_PAINT);
        cursor_drawn = 1'b1;
    endfunction

    // compute the drawing commands of one console transaction and queue them
    function automatic void console_draw_cmds(t_in_item it);
        int unsigned sx;
        t_out_item   tail;
        new_cmds.delete();
        sx = cell_w();
        case (it.action)
            ACT_PUT: begin
                hide_cursor();
                if (it.char_code == CH_LF || it.char_code == CH_CR) begin
                    line_feed();
                end else if (it.char_code == CH_BS) begin
                    if (cur_x >= sx) begin
                        cur_x -= sx;
                        fill_rect(cur_x, cur_y, cur_x + sx, cur_y + cell_h(), BG_PAINT);
                        keep_cell_on_screen();
                    end
                end else begin
                    if (it.char_code[7] == 1'b0)
                        push_cmd(CMD_GLYPH, cur_x, cur_y, 0, 0, it.char_code[6:0], it.color);
                    if (cur_x + sx < cfg_scr_w)
                        cur_x += sx;
                    else
                        line_feed();
                    cur_x &= 32'h1FFF;
                    keep_cell_on_screen();
                end
                show_cursor();
            end
            ACT_BLINK: begin
                if (cursor_on) begin
                    if (cursor_drawn)
                        hide_cursor();
                    else
                        show_cursor();
                end
            end
            ACT_CUR_ON: begin
                cursor_on = 1'b1;
                show_cursor();
            end
            ACT_CUR_OFF: begin
                hide_cursor();
                cursor_on = 1'b0;
            end
            ACT_CLEAR: begin
                fill_rect(0, 0, cfg_scr_w, cfg_scr_h, it.color);
                cur_x = 0;
                cur_y = 0;
                cursor_drawn = 1'b0;
                show_cursor();
            end
            default: begin
            end
        endcase
        if (new_cmds.size() > 0) begin
            tail = new_cmds.pop_back();
            tail.last = 1'b1;
            new_cmds.push_back(tail);
        end
        foreach (new_cmds[i])
            draw_cmds_due.push_back(new_cmds[i]);
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    function automatic t_in_item console_op(logic [2:0] action, logic [7:0] code,
                                            logic [23:0] color);
        t_in_item it;
        it.action    = action;
        it.char_code = code;
        it.color     = color;
        return it;
    endfunction

    function automatic t_in_item random_console_item();
        t_in_item it;
        int       pick;
        pick         = $urandom_range(0, 99);
        it.action    = ACT_PUT;
        it.char_code = 8'($urandom_range(32, 126));
        it.color     = 24'($urandom());
        if (pick < 62) begin
            case ($urandom_range(0, 9))
                0: it.char_code = CH_LF;
                1: it.char_code = CH_CR;
                2, 3: it.char_code = CH_BS;
                4: it.char_code = 8'($urandom_range(0, 255));
                5: it.char_code = 8'($urandom_range(128, 255));
                default: begin
                end
            endcase
        end else if (pick < 74) begin
            it.action = ACT_BLINK;
        end else if (pick < 84) begin
            it.action = ACT_CUR_ON;
        end else if (pick < 92) begin
            it.action = ACT_CUR_OFF;
        end else if (pick < 97) begin
            it.action = ACT_CLEAR;
        end else begin
            it.action = 3'($urandom_range(5, 7));
        end
        return it;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        int hold;
        hold = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_cycles != 0) begin
                hold = long_hold_cycles;
                long_hold_cycles = 0;
            end else if (hold == 0 && out_idle_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 7);
            end
            if (hold != 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                console_draw_cmds(i_in_data);
            if (o_out_valid && i_out_ready) begin
                if (draw_cmds_due.size() == 0) begin
                    $error("unexpected command: %p", o_out_data);
                    fail_count++;
                end else begin
                    next_due = draw_cmds_due.pop_front();
                    check_field("command", 32'(next_due.command), 32'(o_out_data.command));
                    check_field("left", 32'(next_due.left), 32'(o_out_data.left));
                    check_field("top", 32'(next_due.top), 32'(o_out_data.top));
                    check_field("right", 32'(next_due.right), 32'(o_out_data.right));
                    check_field("bottom", 32'(next_due.bottom), 32'(o_out_data.bottom));
                    check_field("glyph_code", 32'(next_due.glyph_code),
                                32'(o_out_data.glyph_code));
                    check_field("paint", 32'(next_due.paint), 32'(o_out_data.paint));
                    check_field("last", 32'(next_due.last), 32'(o_out_data.last));
                end
            end
        end
    end

    // called at a falling edge; leaves valid high so a following transaction can go back to back
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        if (in_idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_item(random_console_item());
    endtask

    // drop valid, wait for every pending command, then let the pipeline settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (draw_cmds_due.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_regs(input int unsigned ts, input int unsigned w, input int unsigned h);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TEXT_SIZE;
        i_cfg_data  <= 13'(ts);
        @(negedge i_clk);
        i_cfg_index <= CFG_SCR_W;
        i_cfg_data  <= 13'(w);
        @(negedge i_clk);
        i_cfg_index <= CFG_SCR_H;
        i_cfg_data  <= 13'(h);
        @(negedge i_clk);
        i_cfg_we      <= 1'b0;
        cfg_text_size = ts & 32'h1F;
        cfg_scr_w     = w & 32'h1FFF;
        cfg_scr_h     = h & 32'h1FFF;
    endtask

    task automatic test_reset_screen();
        send_item(console_op(ACT_CUR_ON, 8'd0, 24'd0));
        send_item(console_op(ACT_PUT, 8'h41, 24'hFFFFFF));
        send_item(console_op(ACT_PUT, 8'h00, 24'h000000));
        send_item(console_op(ACT_PUT, 8'h7F, 24'h5A5AA5));
        send_item(console_op(ACT_PUT, 8'hFF, 24'hA5A55A));
        send_item(console_op(ACT_PUT, CH_BS, 24'd0));
        send_item(console_op(ACT_PUT, CH_LF, 24'd0));
        send_item(console_op(ACT_PUT, CH_CR, 24'd0));
        send_item(console_op(ACT_PUT, CH_BS, 24'd0));
        send_item(console_op(ACT_BLINK, 8'd0, 24'd0));
        send_item(console_op(ACT_BLINK, 8'd0, 24'd0));
        send_item(console_op(ACT_CUR_OFF, 8'd0, 24'd0));
        send_item(console_op(ACT_BLINK, 8'd0, 24'd0));
        send_item(console_op(ACT_CUR_OFF, 8'd0, 24'd0));
        send_item(console_op(ACT_CLEAR, 8'hFF, 24'hFFFFFF));
        send_item(console_op(ACT_CLEAR, 8'h00, 24'h000000));
        send_item(console_op(3'd5, 8'h41, 24'h123456));
        send_item(console_op(3'd6, 8'h0A, 24'hFFFFFF));
        send_item(console_op(3'd7, 8'hFF, 24'h000000));
    endtask

    task automatic test_small_screens();
        // one row of 2x4 cells: the second character wraps and scrolls
        write_regs(1, 4, 4);
        send_item(console_op(ACT_CUR_ON, 8'd0, 24'd0));
        send_item(console_op(ACT_PUT, 8'h78, 24'h00FF00));
        send_item(console_op(ACT_PUT, 8'h79, 24'h0000FF));
        // cell taller than the screen
        write_regs(16, 40, 40);
        send_item(console_op(ACT_PUT, 8'h7A, 24'hFF0000));
        send_item(console_op(ACT_PUT, CH_CR, 24'd0));
        write_regs(1, 1, 1);
        send_item(console_op(ACT_PUT, 8'h61, 24'h808080));
        write_regs(16, 4096, 4096);
        send_item(console_op(ACT_PUT, 8'h4D, 24'h010203));
        send_item(console_op(ACT_CLEAR, 8'd0, 24'hFEDCBA));
    endtask

    task automatic test_random_console();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: write_regs(1, 4096, 4096);
                1: write_regs(16, 1, 1);
                2: write_regs(16, 4096, 4096);
                default: write_regs($urandom_range(1, 16), $urandom_range(1, 96),
                                    $urandom_range(1, 96));
            endcase
            send_random((phase < 3) ? 20 : 44);
        end
    endtask

    task automatic test_output_backpressure();
        write_regs($urandom_range(1, 4), $urandom_range(8, 48), $urandom_range(8, 48));
        in_idle_on = 1'b0;
        long_hold_cycles = 300;
        send_random(30);
        in_idle_on = 1'b1;
    endtask

    task automatic test_sender_pause();
        send_random(10);
        wait_idle();
        send_random(10);
    endtask

    task automatic test_no_idle_tail();
        write_regs($urandom_range(1, 8), $urandom_range(16, 64), $urandom_range(16, 64));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        send_random(60);
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_TEXT_SIZE;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_screen();
        test_small_screens();
        test_random_console();
        test_output_backpressure();
        test_sender_pause();
        test_no_idle_tail();

        wait_idle();
        if (fail_count == 0) begin
            $display("text_console_cursor_engine_test: PASS");
        end else begin
            $display("text_console_cursor_engine_test: FAIL");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("text_console_cursor_engine_test: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tcce_pkg.sv
rtl/core/text_console_cursor_engine.sv
tb/sv/text_console_cursor_engine_test.sv
